// ----- src/qvaf_pkg.sv -----
// ----------------------------------------------------------------------------
// qvaf_pkg
// Shared widths, configuration indexes, face codes and the stencil select type for the QUICK velocity
// adjoint face block.
// ----------------------------------------------------------------------------
package qvaf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration register indexes
  localparam logic CFG_INV_SPACING = 1'b0;
  localparam logic CFG_TIME_STEP   = 1'b1;

  // Face position codes
  localparam logic [1:0] POS_INTERIOR = 2'd0;
  localparam logic [1:0] POS_FIRST    = 2'd1;
  localparam logic [1:0] POS_LAST     = 2'd2;

  // Stencil select: first stencil A or C, second stencil A or D
  typedef struct packed {
    logic sel_first_ac;
    logic sel_second_ad;
    logic use_first;
    logic use_second;
  } qvaf_cls_t;

endpackage

// ----- src/qvaf_mulsh.sv -----
// ----------------------------------------------------------------------------
// qvaf_mulsh
// Signed multiply, round half away from zero on a right shift, saturate.
// One register stage after the product, one after the rounding.
// ----------------------------------------------------------------------------
module qvaf_mulsh #(
  parameter int AW    = 36,
  parameter int BW    = 32,
  parameter int OW    = 32,
  parameter int SHIFT = 19
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [OW-1:0] y,
  output logic                 sat
);

  localparam int PW = AW + BW;

  logic [PW-1:0]        mag_r;
  logic                 neg_r;
  logic [AW-1:0]        ua;
  logic [BW-1:0]        ub;
  logic [PW-1:0]        rnd;
  logic [PW-1:0]        q;
  logic [OW-1:0]        lim;
  logic                 ovf;
  logic signed [OW-1:0] y_nxt;
  logic signed [OW-1:0] y_r;
  logic                 sat_r;

  assign ua = a[AW-1] ? AW'(-a) : AW'(a);
  assign ub = b[BW-1] ? BW'(-b) : BW'(b);

  always_ff @(posedge clk) begin
    mag_r <= PW'(ua) * PW'(ub);
    neg_r <= a[AW-1] ^ b[BW-1];
  end

  always_comb begin
    rnd   = mag_r + (PW'(1) << (SHIFT - 1));
    q     = rnd >> SHIFT;
    lim   = neg_r ? (OW'(1) << (OW - 1)) : ~(OW'(1) << (OW - 1));
    ovf   = (q > PW'(lim));
    y_nxt = ovf ? (neg_r ? -$signed(lim) : $signed(lim))
                : (neg_r ? -$signed(q[OW-1:0]) : $signed(q[OW-1:0]));
  end

  always_ff @(posedge clk) begin
    y_r   <= y_nxt;
    sat_r <= ovf;
  end

  assign y   = y_r;
  assign sat = sat_r;

endmodule

// ----- src/qvaf_front.sv -----
// ----------------------------------------------------------------------------
// qvaf_front
// Classify a face word: sign cases, stencil choice, boundary terms.
// Register the stencil sums and operands for the back part.
// ----------------------------------------------------------------------------
module qvaf_front
  import qvaf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_take,
  input  logic signed [DATA_WIDTH-1:0] vel_prev,
  input  logic signed [DATA_WIDTH-1:0] vel_here,
  input  logic signed [DATA_WIDTH-1:0] vel_next,
  input  logic signed [DATA_WIDTH-1:0] rho_m3,
  input  logic signed [DATA_WIDTH-1:0] rho_m2,
  input  logic signed [DATA_WIDTH-1:0] rho_m1,
  input  logic signed [DATA_WIDTH-1:0] rho_0,
  input  logic signed [DATA_WIDTH-1:0] rho_p1,
  input  logic signed [DATA_WIDTH-1:0] rho_p2,
  input  logic signed [DATA_WIDTH-1:0] up_left,
  input  logic signed [DATA_WIDTH-1:0] up_right,
  input  logic [1:0]                   face_pos,
  output logic                         q_valid,
  output qvaf_cls_t                    q_cls,
  output logic signed [DATA_WIDTH+3:0] q_s1,
  output logic signed [DATA_WIDTH+3:0] q_s2,
  output logic signed [DATA_WIDTH-1:0] q_up_l,
  output logic signed [DATA_WIDTH-1:0] q_up_r
);

  localparam int SW = DATA_WIDTH + 4;

  qvaf_cls_t          cls;
  logic signed [SW-1:0] s1, s2;
  logic signed [SW-1:0] m3, m2, m1, r0, p1, p2;
  logic               valid_r;
  qvaf_cls_t          cls_r;
  logic signed [SW-1:0] s1_r, s2_r;
  logic signed [DATA_WIDTH-1:0] upl_r, upr_r;

  // Case A or C for (a,b) is true exactly when b >= 0 and (a >= 0 or b > 0)
  function automatic logic case_ac(input logic signed [DATA_WIDTH-1:0] a,
                                   input logic signed [DATA_WIDTH-1:0] b);
    logic a_nn, b_nn, b_pos;
    a_nn  = !a[DATA_WIDTH-1];
    b_nn  = !b[DATA_WIDTH-1];
    b_pos = b_nn && (b != '0);
    return (a_nn && b_nn) || (!a_nn && b_pos);
  endfunction

  // Case A or D: A, or D (a > 0, b < 0)
  function automatic logic case_ad(input logic signed [DATA_WIDTH-1:0] a,
                                   input logic signed [DATA_WIDTH-1:0] b);
    logic a_nn, b_nn, a_pos;
    a_nn  = !a[DATA_WIDTH-1];
    b_nn  = !b[DATA_WIDTH-1];
    a_pos = a_nn && (a != '0);
    return (a_nn && b_nn) || (a_pos && !b_nn);
  endfunction

  always_comb begin
    m3 = SW'(rho_m3); m2 = SW'(rho_m2); m1 = SW'(rho_m1);
    r0 = SW'(rho_0);  p1 = SW'(rho_p1); p2 = SW'(rho_p2);
    cls.sel_first_ac  = case_ac(vel_prev, vel_here);
    cls.sel_second_ad = case_ad(vel_here, vel_next);
    cls.use_first     = (face_pos != POS_FIRST);
    cls.use_second    = (face_pos != POS_LAST);
    // eighths: first AC 0,-1,6,3,0  BD 0,0,3,6,-1
    if (cls.sel_first_ac) begin
      s1 = (m1 <<< 2) + (m1 <<< 1) + (r0 <<< 1) + r0 - m2;
    end else begin
      s1 = (r0 <<< 2) + (r0 <<< 1) + (m1 <<< 1) + m1 - p1;
    end
    // second AD 1,-6,-3,0,0  BC 0,-3,-6,1,0
    if (cls.sel_second_ad) begin
      s2 = m2 - (m1 <<< 2) - (m1 <<< 1) - (r0 <<< 1) - r0;
    end else begin
      s2 = p1 - (r0 <<< 2) - (r0 <<< 1) - (m1 <<< 1) - m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls;
    s1_r  <= s1;
    s2_r  <= s2;
    upl_r <= up_left;
    upr_r <= up_right;
  end

  assign q_valid = valid_r;
  assign q_cls   = cls_r;
  assign q_s1    = s1_r;
  assign q_s2    = s2_r;
  assign q_up_l  = upl_r;
  assign q_up_r  = upr_r;

  // rho_m3 and rho_p2 enter only with zero weights in both stencils
  logic unused_taps;
  assign unused_taps = ^{m3, p2};

endmodule

// ----- src/qvaf_back.sv -----
// ----------------------------------------------------------------------------
// qvaf_back
// Scale both stencil sums, weight by upstream gradients, sum, scale by dt.
// Three multiply stages, each with a product and a rounding register, plus a registered sum stage.
// ----------------------------------------------------------------------------
module qvaf_back
  import qvaf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  qvaf_cls_t                    q_cls,
  input  logic signed [DATA_WIDTH+3:0] q_s1,
  input  logic signed [DATA_WIDTH+3:0] q_s2,
  input  logic signed [DATA_WIDTH-1:0] q_up_l,
  input  logic signed [DATA_WIDTH-1:0] q_up_r,
  input  logic [DATA_WIDTH-2:0]        inv_spacing,
  input  logic [DATA_WIDTH-2:0]        time_step,
  output logic                         out_strobe,
  output logic signed [DATA_WIDTH-1:0] out_grad,
  output logic                         out_sat
);

  localparam int DW = DATA_WIDTH;
  localparam int LAT = 7;

  logic [LAT-1:0] vld_r;
  logic signed [DW-1:0] g1, g2, h1, h2, res;
  logic gs1, gs2, hs1, hs2, rs;
  logic signed [DW:0] isp, tst;
  qvaf_cls_t cls_d1_r, cls_d2_r, cls_d3_r, cls_d4_r;
  logic signed [DW-1:0] upl_d1_r, upl_d2_r, upr_d1_r, upr_d2_r;
  logic sat_a_r, sat_b_r, sat_c_r, sat_d_r;
  logic signed [DW+1:0] sum_r;
  logic signed [DW+1:0] sum_nxt;

  assign isp = {2'b00, inv_spacing};
  assign tst = {2'b00, time_step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], q_valid};
    end
  end

  qvaf_mulsh #(.AW(DW+4), .BW(DW+1), .OW(DW), .SHIFT(FRAC_BITS+3)) u_g1 (
    .clk(clk), .a(q_s1), .b(isp), .y(g1), .sat(gs1));
  qvaf_mulsh #(.AW(DW+4), .BW(DW+1), .OW(DW), .SHIFT(FRAC_BITS+3)) u_g2 (
    .clk(clk), .a(q_s2), .b(isp), .y(g2), .sat(gs2));

  always_ff @(posedge clk) begin
    cls_d1_r <= q_cls;    cls_d2_r <= cls_d1_r;
    upl_d1_r <= q_up_l;   upl_d2_r <= upl_d1_r;
    upr_d1_r <= q_up_r;   upr_d2_r <= upr_d1_r;
    cls_d3_r <= cls_d2_r; cls_d4_r <= cls_d3_r;
    sat_a_r  <= (cls_d2_r.use_first && gs1) || (cls_d2_r.use_second && gs2);
    sat_b_r  <= sat_a_r;
  end

  qvaf_mulsh #(.AW(DW), .BW(DW), .OW(DW), .SHIFT(FRAC_BITS)) u_h1 (
    .clk(clk), .a(g1), .b(upl_d2_r), .y(h1), .sat(hs1));
  qvaf_mulsh #(.AW(DW), .BW(DW), .OW(DW), .SHIFT(FRAC_BITS)) u_h2 (
    .clk(clk), .a(g2), .b(upr_d2_r), .y(h2), .sat(hs2));

  // drop terms of the missing side at boundary faces, negate the total
  always_comb begin
    sum_nxt = '0;
    if (cls_d4_r.use_first)  sum_nxt = sum_nxt - (DW+2)'(h1);
    if (cls_d4_r.use_second) sum_nxt = sum_nxt - (DW+2)'(h2);
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    sat_c_r <= sat_b_r || (cls_d4_r.use_first && hs1) || (cls_d4_r.use_second && hs2);
    sat_d_r <= sat_c_r;
  end

  qvaf_mulsh #(.AW(DW+2), .BW(DW+1), .OW(DW), .SHIFT(FRAC_BITS)) u_res (
    .clk(clk), .a(sum_r), .b(tst), .y(res), .sat(rs));

  logic sat_e_r;
  always_ff @(posedge clk) begin
    sat_e_r <= sat_d_r;
  end

  assign out_strobe = vld_r[LAT-1];
  assign out_grad   = res;
  assign out_sat    = sat_e_r || rs;

endmodule

// ----- src/quick_velocity_adjoint_face.sv -----
// From start to out_strobe a face word passes the classify register, then the multiply chain.
// Throughput: one face word per cycle; every stage is pipelined, so busy stays low.
// The receiver cannot stall; each result shows for one cycle with out_strobe.
// Reset (rst_n low, synchronous) clears the in-flight valid bits and sets
// inv_spacing and time_step to 1.0.
// ----------------------------------------------------------------------------
// quick_velocity_adjoint_face
// Gradient of QUICK upwind advection with respect to one face velocity.
// ----------------------------------------------------------------------------
module quick_velocity_adjoint_face
  import qvaf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_vel_prev,
  input  logic signed [DATA_WIDTH-1:0] in_vel_here,
  input  logic signed [DATA_WIDTH-1:0] in_vel_next,
  input  logic signed [DATA_WIDTH-1:0] in_rho_m3,
  input  logic signed [DATA_WIDTH-1:0] in_rho_m2,
  input  logic signed [DATA_WIDTH-1:0] in_rho_m1,
  input  logic signed [DATA_WIDTH-1:0] in_rho_0,
  input  logic signed [DATA_WIDTH-1:0] in_rho_p1,
  input  logic signed [DATA_WIDTH-1:0] in_rho_p2,
  input  logic signed [DATA_WIDTH-1:0] in_upstream_left,
  input  logic signed [DATA_WIDTH-1:0] in_upstream_right,
  input  logic [1:0]                   in_face_position,
  output logic                         out_strobe,
  output logic signed [DATA_WIDTH-1:0] out_velocity_gradient,
  output logic                         out_saturated,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [DATA_WIDTH-2:0]        cfg_data
);

  logic [DATA_WIDTH-2:0] inv_spacing_r, time_step_r;
  logic                  q_valid;
  qvaf_cls_t             q_cls;
  logic signed [DATA_WIDTH+3:0] q_s1, q_s2;
  logic signed [DATA_WIDTH-1:0] q_up_l, q_up_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_spacing_r <= (DATA_WIDTH-1)'(1) << FRAC_BITS;
      time_step_r   <= (DATA_WIDTH-1)'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      if (cfg_index == CFG_INV_SPACING) inv_spacing_r <= cfg_data;
      if (cfg_index == CFG_TIME_STEP)   time_step_r   <= cfg_data;
    end
  end

  qvaf_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_take(start && !busy),
    .vel_prev(in_vel_prev), .vel_here(in_vel_here), .vel_next(in_vel_next),
    .rho_m3(in_rho_m3), .rho_m2(in_rho_m2), .rho_m1(in_rho_m1),
    .rho_0(in_rho_0), .rho_p1(in_rho_p1), .rho_p2(in_rho_p2),
    .up_left(in_upstream_left), .up_right(in_upstream_right),
    .face_pos(in_face_position),
    .q_valid(q_valid), .q_cls(q_cls), .q_s1(q_s1), .q_s2(q_s2),
    .q_up_l(q_up_l), .q_up_r(q_up_r));

  qvaf_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cls(q_cls),
    .q_s1(q_s1), .q_s2(q_s2), .q_up_l(q_up_l), .q_up_r(q_up_r),
    .inv_spacing(inv_spacing_r), .time_step(time_step_r),
    .out_strobe(out_strobe), .out_grad(out_velocity_gradient),
    .out_sat(out_saturated));

endmodule

// ----- src/qvaf_checker.sv -----
// ----------------------------------------------------------------------------
// qvaf_checker
// Port-level checks: fixed latency, no spurious results, busy never raised, known result words.
// ----------------------------------------------------------------------------
module qvaf_checker
  import qvaf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_strobe,
  input logic [DATA_WIDTH-1:0] out_velocity_gradient,
  input logic                  out_saturated
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_strobe) else $error("result word missing");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(rst_n, 8)) |-> $past(start && !busy, 8))
    else $error("spurious result word");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("busy raised");

  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown({out_velocity_gradient, out_saturated}))
    else $error("unknown result word");

endmodule

bind quick_velocity_adjoint_face qvaf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qvaf_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_velocity_gradient(out_velocity_gradient),
  .out_saturated(out_saturated));
